>>> design/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants
// Request and result formats, opcodes, commands and status codes of the
// two-register stack processor.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int          MEM_WORDS_DEF    = 4096;
    localparam int          APB_AW           = 3;
    localparam logic [19:0] STEP_LIMIT_RESET = 20'd1000000;
    localparam logic        REG_STEP_LIMIT   = 1'b0;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [7:0] OP_LDC  = 8'd0;
    localparam logic [7:0] OP_ADC  = 8'd1;
    localparam logic [7:0] OP_LDL  = 8'd2;
    localparam logic [7:0] OP_STL  = 8'd3;
    localparam logic [7:0] OP_LDNL = 8'd4;
    localparam logic [7:0] OP_STNL = 8'd5;
    localparam logic [7:0] OP_ADD  = 8'd6;
    localparam logic [7:0] OP_SUB  = 8'd7;
    localparam logic [7:0] OP_SHL  = 8'd8;
    localparam logic [7:0] OP_SHR  = 8'd9;
    localparam logic [7:0] OP_ADJ  = 8'd10;
    localparam logic [7:0] OP_A2SP = 8'd11;
    localparam logic [7:0] OP_SP2A = 8'd12;
    localparam logic [7:0] OP_CALL = 8'd13;
    localparam logic [7:0] OP_RET  = 8'd14;
    localparam logic [7:0] OP_BRZ  = 8'd15;
    localparam logic [7:0] OP_BRLZ = 8'd16;
    localparam logic [7:0] OP_BR   = 8'd17;
    localparam logic [7:0] OP_HALT = 8'd18;

    typedef enum logic [2:0] {
        ST_RAN       = 3'd0,
        ST_HALTED    = 3'd1,
        ST_LEFT_CODE = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_BAD_ADDR  = 3'd4,
        ST_LIMIT     = 3'd5,
        ST_LOADED    = 3'd6,
        ST_STOPPED   = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] program_word;
    } t_in;

    typedef struct packed {
        logic signed [31:0] acc_a;
        logic signed [31:0] acc_b;
        logic signed [31:0] stack_ptr;
        logic signed [31:0] prog_counter;
        logic [7:0]         executed_opcode;
        logic signed [23:0] operand_value;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sp;
        logic [31:0] pc;
    } t_regs;

    typedef struct packed {
        logic    rd;
        logic    wr;
        t_status status;
    } t_exec_ctl;

endpackage

>>> design/tsc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_mem: word store
// Single-port-write, single-port-read synchronous memory with a registered
// read output.
// ----------------------------------------------------------------------------
module tsc_mem #(
    parameter int MEM_WORDS = 4096,
    parameter int AW        = 12
) (
    input  logic          i_clk,
    input  logic          i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_rd,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tsc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_alu: instruction execute logic
// Decodes one fetched word and computes the next register values, the
// status and the data memory request.
// ----------------------------------------------------------------------------
module tsc_alu #(
    parameter int MEM_WORDS = 4096,
    parameter int AW        = 12
) (
    input  tsc_pkg::t_regs     i_regs,
    input  logic [31:0]        i_instr,
    output tsc_pkg::t_regs     o_regs,
    output tsc_pkg::t_exec_ctl o_ctl,
    output logic [AW-1:0]      o_addr,
    output logic [31:0]        o_wdata
);
    import tsc_pkg::*;

    localparam logic [32:0] MemTop = 33'(MEM_WORDS);

    logic [7:0]  opc;
    logic [31:0] op;
    logic [31:0] base;
    logic [32:0] addr_sum;
    logic        addr_ok;
    logic [32:0] adc_sum;
    logic [32:0] add_sum;
    logic [32:0] sub_dif;
    logic [31:0] pc_inc;
    logic [31:0] target;

    assign opc      = i_instr[7:0];
    assign op       = {{8{i_instr[31]}}, i_instr[31:8]};
    assign base     = (opc == OP_LDL || opc == OP_STL) ? i_regs.sp : i_regs.a;
    assign addr_sum = {base[31], base} + {op[31], op};
    assign addr_ok  = !addr_sum[32] && (addr_sum < MemTop);
    assign adc_sum  = {i_regs.a[31], i_regs.a} + {op[31], op};
    assign add_sum  = {i_regs.b[31], i_regs.b} + {i_regs.a[31], i_regs.a};
    assign sub_dif  = {i_regs.b[31], i_regs.b} - {i_regs.a[31], i_regs.a};
    assign pc_inc   = i_regs.pc + 32'd1;
    assign target   = pc_inc + op;
    assign o_addr   = addr_sum[AW-1:0];

    always_comb begin
        o_regs       = i_regs;
        o_regs.pc    = pc_inc;
        o_ctl.rd     = 1'b0;
        o_ctl.wr     = 1'b0;
        o_ctl.status = ST_RAN;
        o_wdata      = i_regs.a;
        unique case (opc)
            OP_LDC: begin
                o_regs.b = i_regs.a;
                o_regs.a = op;
            end
            OP_ADC: begin
                if (adc_sum[32] != adc_sum[31]) begin
                    o_ctl.status = ST_OVERFLOW;
                end else begin
                    o_regs.a = adc_sum[31:0];
                end
            end
            OP_LDL: begin
                o_regs.b = i_regs.a;
                if (!addr_ok) begin
                    o_ctl.status = ST_BAD_ADDR;
                end else begin
                    o_ctl.rd = 1'b1;
                end
            end
            OP_STL: begin
                if (!addr_ok) begin
                    o_ctl.status = ST_BAD_ADDR;
                end else begin
                    o_ctl.wr = 1'b1;
                    o_regs.a = i_regs.b;
                end
            end
            OP_LDNL: begin
                if (!addr_ok) begin
                    o_ctl.status = ST_BAD_ADDR;
                end else begin
                    o_ctl.rd = 1'b1;
                end
            end
            OP_STNL: begin
                o_wdata = i_regs.b;
                if (!addr_ok) begin
                    o_ctl.status = ST_BAD_ADDR;
                end else begin
                    o_ctl.wr = 1'b1;
                end
            end
            OP_ADD: begin
                if (add_sum[32] != add_sum[31]) begin
                    o_ctl.status = ST_OVERFLOW;
                end else begin
                    o_regs.a = add_sum[31:0];
                end
            end
            OP_SUB: begin
                if (sub_dif[32] != sub_dif[31]) begin
                    o_ctl.status = ST_OVERFLOW;
                end else begin
                    o_regs.a = sub_dif[31:0];
                end
            end
            OP_SHL: begin
                o_regs.a = i_regs.b << i_regs.a[4:0];
            end
            OP_SHR: begin
                o_regs.a = $unsigned($signed(i_regs.b) >>> i_regs.a[4:0]);
            end
            OP_ADJ: begin
                o_regs.sp = i_regs.sp + op;
            end
            OP_A2SP: begin
                o_regs.sp = i_regs.a;
                o_regs.a  = i_regs.b;
            end
            OP_SP2A: begin
                o_regs.b = i_regs.a;
                o_regs.a = i_regs.sp;
            end
            OP_CALL: begin
                o_regs.b  = i_regs.a;
                o_regs.a  = pc_inc;
                o_regs.pc = target;
            end
            OP_RET: begin
                o_regs.pc = i_regs.a;
                o_regs.a  = i_regs.b;
            end
            OP_BRZ: begin
                if (i_regs.a == 32'd0) begin
                    o_regs.pc = target;
                end
            end
            OP_BRLZ: begin
                if (i_regs.a[31]) begin
                    o_regs.pc = target;
                end
            end
            OP_BR: begin
                o_regs.pc = target;
            end
            OP_HALT: begin
                o_ctl.status = ST_HALTED;
            end
            default: begin
                o_regs.pc = pc_inc;
            end
        endcase
    end

endmodule

>>> design/two_register_stack_cpu_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_register_stack_cpu_execute: two-register stack processor
// Sequencer, architectural registers and configuration port around the word
// store and the execute logic.
// ----------------------------------------------------------------------------
// Requests arrive on a valid/ready channel; each carries a command (load a
// program word, step one instruction, restart the run) and a program word.
// Every request produces exactly one result on the output valid/ready
// channel, holding the registers after the request, the executed opcode and
// operand, and a status code.
// Load, restart and steps that execute nothing pass from the request to the
// result state and then the result register. A step passes the fetch read of
// the word store, execute, then the result register; loads from data memory
// add a read of the data word between execute and the result. Requests are
// handled one at a time.
// After reset the block clears the word store, one word per cycle, from word
// 0 to MEM_WORDS-1; no request is accepted during that pass, though the
// step limit register can be written. The step limit resets to 1000000.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted meanwhile, but its result waits behind it.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_execute #(
    parameter int MEM_WORDS = tsc_pkg::MEM_WORDS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tsc_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tsc_pkg::t_out             o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tsc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tsc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int CW = AW + 1;

    t_state       r_state, n_state;
    t_regs        r_regs, n_regs;
    logic [CW-1:0] r_code_len, n_code_len;
    logic [19:0]  r_steps, n_steps;
    logic         r_stopped, n_stopped;
    logic [19:0]  r_limit, n_limit;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [7:0]   r_opc, n_opc;
    logic [23:0]  r_op, n_op;
    t_status      r_status, n_status;
    logic         r_out_valid, n_out_valid;
    t_out         r_out, n_out;

    logic          mem_wr;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_rd;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    t_regs         alu_regs;
    t_exec_ctl     alu_ctl;
    logic [AW-1:0] alu_addr;
    logic [31:0]   alu_wdata;

    logic accept;
    logic out_free;
    logic pc_bad;
    logic limit_hit;
    logic step_exec;
    logic cfg_wr;

    tsc_mem #(
        .MEM_WORDS(MEM_WORDS),
        .AW       (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_wr   (mem_wr),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_rd   (mem_rd),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    tsc_alu #(
        .MEM_WORDS(MEM_WORDS),
        .AW       (AW)
    ) u_alu (
        .i_regs (r_regs),
        .i_instr(mem_rdata),
        .o_regs (alu_regs),
        .o_ctl  (alu_ctl),
        .o_addr (alu_addr),
        .o_wdata(alu_wdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign pc_bad      = r_regs.pc[31] || (r_regs.pc >= 32'(r_code_len));
    assign limit_hit   = (r_steps >= r_limit);
    assign step_exec   = (i_in_data.command == CMD_STEP) && !r_stopped && !pc_bad
                         && !limit_hit;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_STEP_LIMIT) ? {12'd0, r_limit} : 32'd0;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = step_exec ? S_EXEC : S_RESP;
                end
            end
            S_EXEC: begin
                n_state = alu_ctl.rd ? S_LOAD : S_RESP;
            end
            S_LOAD: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_regs      = r_regs;
        n_code_len  = r_code_len;
        n_steps     = r_steps;
        n_stopped   = r_stopped;
        n_clr_addr  = r_clr_addr;
        n_opc       = r_opc;
        n_op        = r_op;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_limit     = (cfg_wr && paddr[2] == REG_STEP_LIMIT) ? pwdata[19:0] : r_limit;
        mem_wr      = 1'b0;
        mem_waddr   = r_clr_addr;
        mem_wdata   = 32'd0;
        mem_rd      = 1'b0;
        mem_raddr   = r_regs.pc[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_wr     = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_opc    = 8'd0;
                    n_op     = 24'd0;
                    n_status = ST_RAN;
                    unique case (i_in_data.command)
                        CMD_LOAD: begin
                            n_status = ST_LOADED;
                            if (r_code_len < CW'(MEM_WORDS)) begin
                                mem_wr     = 1'b1;
                                mem_waddr  = r_code_len[AW-1:0];
                                mem_wdata  = i_in_data.program_word;
                                n_code_len = r_code_len + CW'(1);
                            end
                        end
                        CMD_RESTART: begin
                            n_regs    = '0;
                            n_steps   = 20'd0;
                            n_stopped = 1'b0;
                        end
                        CMD_STEP: begin
                            if (r_stopped) begin
                                n_status = ST_STOPPED;
                            end else if (pc_bad) begin
                                n_status  = ST_LEFT_CODE;
                                n_stopped = 1'b1;
                            end else if (limit_hit) begin
                                n_status  = ST_LIMIT;
                                n_stopped = 1'b1;
                            end else begin
                                mem_rd  = 1'b1;
                                n_steps = r_steps + 20'd1;
                            end
                        end
                        default: begin
                            n_status = ST_RAN;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_regs    = alu_regs;
                n_opc     = mem_rdata[7:0];
                n_op      = mem_rdata[31:8];
                n_status  = alu_ctl.status;
                n_stopped = r_stopped || (alu_ctl.status != ST_RAN);
                mem_wr    = alu_ctl.wr;
                mem_waddr = alu_addr;
                mem_wdata = alu_wdata;
                mem_rd    = alu_ctl.rd;
                mem_raddr = alu_addr;
            end
            S_LOAD: begin
                n_regs.a = mem_rdata;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.acc_a           = r_regs.a;
                    n_out.acc_b           = r_regs.b;
                    n_out.stack_ptr       = r_regs.sp;
                    n_out.prog_counter    = r_regs.pc;
                    n_out.executed_opcode = r_opc;
                    n_out.operand_value   = r_op;
                    n_out.status          = r_status;
                end
            end
            default: begin
                mem_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_regs      <= '0;
            r_code_len  <= '0;
            r_steps     <= 20'd0;
            r_stopped   <= 1'b0;
            r_limit     <= STEP_LIMIT_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_regs      <= n_regs;
            r_code_len  <= n_code_len;
            r_steps     <= n_steps;
            r_stopped   <= n_stopped;
            r_limit     <= n_limit;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_opc    <= n_opc;
        r_op     <= n_op;
        r_status <= n_status;
        r_out    <= n_out;
    end

endmodule

>>> design/tsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_checker: port-level checks
// Concurrent assertions on the request and result channels of the
// two-register stack processor, bound to its top level.
// ----------------------------------------------------------------------------
module tsc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tsc_pkg::t_out o_out_data
);
    import tsc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed or dropped while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Request accepted while the previous one is in flight.");

    a_no_exec_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_LOADED || o_out_data.status == ST_STOPPED
        || o_out_data.status == ST_LEFT_CODE || o_out_data.status == ST_LIMIT)
        |-> o_out_data.executed_opcode == 8'd0 && o_out_data.operand_value == 24'sd0)
        else $error("Opcode or operand reported without an executed instruction.");

    a_halt_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_HALTED
        |-> o_out_data.executed_opcode == OP_HALT)
        else $error("Halted status without a halt instruction.");

    a_ovf_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_OVERFLOW
        |-> o_out_data.executed_opcode == OP_ADC || o_out_data.executed_opcode == OP_ADD
        || o_out_data.executed_opcode == OP_SUB)
        else $error("Overflow status from an instruction that cannot overflow.");

endmodule

bind two_register_stack_cpu_execute tsc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

>>> tb/cpu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_result_checker: result prediction and comparison for the stack processor
// Watches the request, result and configuration channels. Every accepted
// request is run through a private copy of the processor state to predict
// its result, and every accepted result is compared field by field against
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cpu_result_checker #(
    parameter int MEM_WORDS = tsc_pkg::MEM_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  tsc_pkg::t_in               i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  tsc_pkg::t_out              i_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         o_fail_count,
    output int                         o_pending
);
    import tsc_pkg::*;

    localparam logic [APB_AW-1:0] STEP_LIMIT_ADDR = APB_AW'(4 * REG_STEP_LIMIT);

    logic [31:0] mem_q [MEM_WORDS];
    int unsigned code_count;
    logic [31:0] a_q;
    logic [31:0] b_q;
    logic [31:0] sp_q;
    logic [31:0] pc_q;
    logic [19:0] step_count;
    logic [19:0] limit_q;
    bit          halted;
    t_out        awaited_results [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 100) begin
            $display("checker: %s mismatch at %0t ns: got %h, expected %h",
                     what, $time, got, want);
        end
    endtask

    function automatic void clear_machine();
        a_q = '0;
        b_q = '0;
        sp_q = '0;
        pc_q = '0;
        step_count = '0;
        halted = 1'b0;
    endfunction

    function automatic bit mem_index_ok(input logic [31:0] base, input logic [31:0] off,
                                        output int unsigned idx);
        logic signed [32:0] t;
        t = $signed({base[31], base}) + $signed({off[31], off});
        idx = t[31:0];
        return !(t < 0 || t >= MEM_WORDS);
    endfunction

    function automatic t_status exec_instruction(input logic [7:0] opc,
                                                 input logic [31:0] op);
        logic [31:0] prev;
        logic [32:0] r;
        int unsigned idx;
        prev = pc_q;
        pc_q = prev + 1;
        case (opc)
            OP_LDC: begin
                b_q = a_q;
                a_q = op;
            end
            OP_ADC: begin
                r = {a_q[31], a_q} + {op[31], op};
                if (r[32] != r[31]) return ST_OVERFLOW;
                a_q = r[31:0];
            end
            OP_LDL: begin
                b_q = a_q;
                if (!mem_index_ok(sp_q, op, idx)) return ST_BAD_ADDR;
                a_q = mem_q[idx];
            end
            OP_STL: begin
                if (!mem_index_ok(sp_q, op, idx)) return ST_BAD_ADDR;
                mem_q[idx] = a_q;
                a_q = b_q;
            end
            OP_LDNL: begin
                if (!mem_index_ok(a_q, op, idx)) return ST_BAD_ADDR;
                a_q = mem_q[idx];
            end
            OP_STNL: begin
                if (!mem_index_ok(a_q, op, idx)) return ST_BAD_ADDR;
                mem_q[idx] = b_q;
            end
            OP_ADD: begin
                r = {b_q[31], b_q} + {a_q[31], a_q};
                if (r[32] != r[31]) return ST_OVERFLOW;
                a_q = r[31:0];
            end
            OP_SUB: begin
                r = {b_q[31], b_q} - {a_q[31], a_q};
                if (r[32] != r[31]) return ST_OVERFLOW;
                a_q = r[31:0];
            end
            OP_SHL:  a_q = b_q << a_q[4:0];
            OP_SHR:  a_q = $unsigned($signed(b_q) >>> a_q[4:0]);
            OP_ADJ:  sp_q = sp_q + op;
            OP_A2SP: begin
                sp_q = a_q;
                a_q = b_q;
            end
            OP_SP2A: begin
                b_q = a_q;
                a_q = sp_q;
            end
            OP_CALL: begin
                b_q = a_q;
                a_q = pc_q;
                pc_q = prev + 1 + op;
            end
            OP_RET: begin
                pc_q = a_q;
                a_q = b_q;
            end
            OP_BRZ:  if (a_q == 0) pc_q = prev + 1 + op;
            OP_BRLZ: if (a_q[31]) pc_q = prev + 1 + op;
            OP_BR:   pc_q = prev + 1 + op;
            OP_HALT: return ST_HALTED;
            default: ;
        endcase
        return ST_RAN;
    endfunction

    function automatic t_out next_cpu_result(input t_in req);
        t_out        res;
        logic [31:0] instr;
        logic [31:0] op;
        logic [7:0]  opc;
        t_status     st;
        opc = '0;
        op = '0;
        st = ST_RAN;
        case (req.command)
            CMD_LOAD: begin
                if (code_count < MEM_WORDS) begin
                    mem_q[code_count] = req.program_word;
                    code_count++;
                end
                st = ST_LOADED;
            end
            CMD_RESTART: clear_machine();
            CMD_STEP: begin
                if (halted) begin
                    st = ST_STOPPED;
                end else if (pc_q[31] || pc_q >= code_count) begin
                    st = ST_LEFT_CODE;
                    halted = 1'b1;
                end else if (step_count >= limit_q) begin
                    st = ST_LIMIT;
                    halted = 1'b1;
                end else begin
                    instr = mem_q[pc_q];
                    step_count = step_count + 1'b1;
                    opc = instr[7:0];
                    op = {{8{instr[31]}}, instr[31:8]};
                    st = exec_instruction(opc, op);
                    if (st != ST_RAN) halted = 1'b1;
                end
            end
            default: ;
        endcase
        res.acc_a = a_q;
        res.acc_b = b_q;
        res.stack_ptr = sp_q;
        res.prog_counter = pc_q;
        res.executed_opcode = opc;
        res.operand_value = op[23:0];
        res.status = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++) mem_q[i] = '0;
            code_count = 0;
            limit_q = STEP_LIMIT_RESET;
            clear_machine();
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == STEP_LIMIT_ADDR) begin
                limit_q = pwdata[19:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited", i_out_data.status, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.acc_a !== want.acc_a)
                        report_mismatch("acc_a", i_out_data.acc_a, want.acc_a);
                    if (i_out_data.acc_b !== want.acc_b)
                        report_mismatch("acc_b", i_out_data.acc_b, want.acc_b);
                    if (i_out_data.stack_ptr !== want.stack_ptr)
                        report_mismatch("stack_ptr", i_out_data.stack_ptr, want.stack_ptr);
                    if (i_out_data.prog_counter !== want.prog_counter)
                        report_mismatch("prog_counter", i_out_data.prog_counter,
                                        want.prog_counter);
                    if (i_out_data.executed_opcode !== want.executed_opcode)
                        report_mismatch("executed_opcode", i_out_data.executed_opcode,
                                        want.executed_opcode);
                    if (i_out_data.operand_value !== want.operand_value)
                        report_mismatch("operand_value", i_out_data.operand_value,
                                        want.operand_value);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(next_cpu_result(i_in_data));
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the two-register stack processor
// Loads small programs behind a fixed dispatcher at address zero, restarts
// and steps them under several step limits, and lets the checker predict
// and compare every result.
// ----------------------------------------------------------------------------
module testbench;
    import tsc_pkg::*;

    localparam int                MEM_WORDS       = MEM_WORDS_DEF;
    localparam logic [1:0]        CMD_UNUSED      = 2'd3;
    localparam logic [APB_AW-1:0] STEP_LIMIT_ADDR = APB_AW'(4 * REG_STEP_LIMIT);
    // Word that holds the start address of the newest program.
    localparam int                VEC_ADDR        = 2;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in               in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;

    int                sent       = 0;
    int                code_words = 0;
    bit                calm       = 1'b0;
    logic [31:0]       body [$];

    two_register_stack_cpu_execute #(.MEM_WORDS(MEM_WORDS)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    cpu_result_checker #(.MEM_WORDS(MEM_WORDS)) result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 13);
    end

    function automatic logic [31:0] enc(input logic [7:0] opc, input int operand);
        return {operand[23:0], opc};
    endfunction

    task automatic send_req(input logic [1:0] cmd, input logic [31:0] word);
        if (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {cmd, word};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        if (cmd == CMD_LOAD && code_words < MEM_WORDS) code_words++;
        calm <= (sent >= 500 && sent < 800);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_step_limit(input logic [19:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STEP_LIMIT_ADDR;
        pwdata <= {12'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Each program opens by pointing the dispatcher at the code loaded after it.
    task automatic load_block();
        int next_addr;
        next_addr = code_words + 3 + body.size();
        send_req(CMD_LOAD, enc(OP_LDC, next_addr));
        send_req(CMD_LOAD, enc(OP_LDC, 0));
        send_req(CMD_LOAD, enc(OP_STNL, VEC_ADDR));
        foreach (body[j]) send_req(CMD_LOAD, body[j]);
    endtask

    initial begin
        int          r;
        int          r2;
        int          len;
        int          span;
        int          nsteps;
        int          operand;
        int          phase;
        logic [7:0]  opc;
        logic [19:0] lim;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_step_limit(STEP_LIMIT_RESET);

        send_req(CMD_UNUSED, 32'hFFFF_FFFF);
        send_req(CMD_STEP, 32'h0);
        send_req(CMD_STEP, 32'h0);
        send_req(CMD_LOAD, enc(OP_LDL, VEC_ADDR));
        send_req(CMD_LOAD, enc(OP_RET, 0));
        send_req(CMD_LOAD, VEC_ADDR + 1);
        body = {enc(OP_LDC, 32'h7F_FFFF), enc(OP_LDC, 32'h80_0000), enc(OP_ADD, 0),
                enc(OP_ADC, 1), enc(OP_HALT, 0), 32'hFFFF_FFFF};
        load_block();
        send_req(CMD_RESTART, 32'h0);
        repeat (11) send_req(CMD_STEP, $urandom);

        phase = 0;
        while (sent < 1450) begin
            drain();
            if (phase < 2 || $urandom_range(1)) begin
                r = $urandom_range(99);
                if (phase == 0) lim = 20'hFFFFF;
                else if (phase == 1) lim = 20'd1;
                else if (r < 10) lim = 20'd1;
                else if (r < 20) lim = 20'hFFFFF;
                else if (r < 30) lim = STEP_LIMIT_RESET;
                else if (r < 75) lim = 20'($urandom_range(2, 30));
                else lim = 20'($urandom_range(1, 20'hFFFFF));
                write_step_limit(lim);
            end

            body.delete();
            len = $urandom_range(3, 16);
            span = code_words + len + 7;
            while (body.size() < len) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    body.push_back($urandom);
                end else if (r < 14) begin
                    // Shifting a 24-bit extreme up to the 32-bit range sets up overflow.
                    body.push_back(enc(OP_LDC, $urandom_range(1) ? 32'h7F_FFFF : 32'h80_0000));
                    body.push_back(enc(OP_LDC, 8));
                    body.push_back(enc(OP_SHL, 0));
                    case ($urandom_range(2))
                        0:       body.push_back(enc(OP_ADC, $urandom));
                        1:       body.push_back(enc(OP_SUB, 0));
                        default: body.push_back(enc(OP_ADD, 0));
                    endcase
                end else begin
                    opc = (r < 17) ? 8'($urandom_range(19, 255)) : 8'($urandom_range(18));
                    r2 = $urandom_range(99);
                    case (opc)
                        OP_LDC, OP_ADC: begin
                            if (r2 < 30) begin
                                operand = int'($urandom_range(48)) - 8;
                            end else if (r2 < 55) begin
                                case ($urandom_range(3))
                                    0:       operand = 32'h7F_FFFF;
                                    1:       operand = 32'h80_0000;
                                    2:       operand = -1;
                                    default: operand = 0;
                                endcase
                            end else begin
                                operand = $urandom;
                            end
                        end
                        OP_LDL, OP_STL, OP_LDNL, OP_STNL: begin
                            if (r2 < 70) operand = $urandom_range(span - 1);
                            else if (r2 < 80) operand = MEM_WORDS - 2 + $urandom_range(3);
                            else if (r2 < 90) operand = -1 - int'($urandom_range(2));
                            else operand = $urandom;
                        end
                        OP_CALL, OP_BRZ, OP_BRLZ, OP_BR: begin
                            if (r2 < 80) operand = int'($urandom_range(len)) - body.size() - 1;
                            else operand = $urandom;
                        end
                        OP_ADJ:  operand = int'($urandom_range(8)) - 4;
                        default: operand = $urandom;
                    endcase
                    body.push_back(enc(opc, operand));
                end
            end
            if ($urandom_range(1)) body.push_back(enc(OP_HALT, $urandom));
            load_block();

            send_req(CMD_RESTART, $urandom);
            nsteps = body.size() + 5 + $urandom_range(4);
            for (int k = 0; k < nsteps; k++) begin
                r = $urandom_range(99);
                if (r < 4) send_req(CMD_UNUSED, $urandom);
                else if (r < 6) send_req(CMD_RESTART, $urandom);
                send_req(CMD_STEP, $urandom);
            end
            phase++;
        end

        drain();
        write_step_limit(STEP_LIMIT_RESET);
        send_req(CMD_RESTART, $urandom);
        repeat (12) send_req(CMD_STEP, $urandom);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
